// ===== rtl/core/lba_to_chs_translate_defines.svh =====
// ---------------------------------------------------------------------------
// lba_to_chs_translate_defines.svh
// Assertion macros used by the LBA to CHS translator top level.
// ---------------------------------------------------------------------------
`ifndef LBA_TO_CHS_TRANSLATE_DEFINES_SVH
`define LBA_TO_CHS_TRANSLATE_DEFINES_SVH

// same-cycle implication, disabled in reset
`define LCT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define LCT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/lct_pkg.sv =====
// ---------------------------------------------------------------------------
// lct_pkg
// Shared types and constants of the LBA to CHS translator.
// ---------------------------------------------------------------------------
`default_nettype none

package lct_pkg;

  localparam int ADDRESS_BITS_DEFAULT = 32;
  localparam int CFG_DATA_W           = 11;
  localparam int CFG_INDEX_W          = 2;
  localparam int PER_CYL_W            = 14;  // 256 * 63 fits in 14 bits
  localparam int SPT_W                = 6;
  localparam int HEAD_DIV_STEPS       = PER_CYL_W;

  localparam logic [10:0] CYL_COUNT_RESET = 11'd1024;
  localparam logic [8:0]  HEAD_COUNT_RESET = 9'd255;
  localparam logic [5:0]  SPT_RESET       = 6'd63;
  localparam logic [7:0]  DRIVE_RESET     = 8'd128;
  localparam logic [8:0]  MAX_HEADS       = 9'd256;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_CYL_COUNT  = 2'd0,
    CFG_HEAD_COUNT = 2'd1,
    CFG_SPT        = 2'd2,
    CFG_DRIVE      = 2'd3
  } cfg_index_t;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_BEYOND   = 2'd1,
    STATUS_BAD_GEOM = 2'd2
  } status_t;

  typedef struct packed {
    logic [10:0]          cylinder_count;
    logic [8:0]           head_count;
    logic [SPT_W-1:0]     sectors_per_track;
    logic [7:0]           drive_number;
    logic [PER_CYL_W-1:0] per_cyl;
  } cfg_t;

endpackage

`default_nettype wire

// ===== rtl/core/lct_cfg_regs.sv =====
// ---------------------------------------------------------------------------
// lct_cfg_regs
// Geometry registers and the registered sectors-per-cylinder product.
// ---------------------------------------------------------------------------
`default_nettype none

module lct_cfg_regs (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_valid,
  input  wire logic [lct_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [lct_pkg::CFG_DATA_W-1:0]  cfg_data,
  output lct_pkg::cfg_t                        cfg
);
  import lct_pkg::*;

  logic [10:0]          cylinder_count;
  logic [8:0]           head_count;
  logic [SPT_W-1:0]     sectors_per_track;
  logic [7:0]           drive_number;
  logic [PER_CYL_W-1:0] per_cyl;
  logic [8:0]           heads_clamped;
  logic [14:0]          product;

  always_ff @(posedge clk) begin
    if (rst) begin
      cylinder_count    <= CYL_COUNT_RESET;
      head_count        <= HEAD_COUNT_RESET;
      sectors_per_track <= SPT_RESET;
      drive_number      <= DRIVE_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index_t'(cfg_index))
        CFG_CYL_COUNT:  cylinder_count    <= cfg_data[10:0];
        CFG_HEAD_COUNT: head_count        <= cfg_data[8:0];
        CFG_SPT:        sectors_per_track <= cfg_data[SPT_W-1:0];
        CFG_DRIVE:      drive_number      <= cfg_data[7:0];
        default: begin
        end
      endcase
    end
  end

  assign heads_clamped = (head_count > MAX_HEADS) ? MAX_HEADS : head_count;
  assign product       = 15'(heads_clamped) * 15'(sectors_per_track);

  always_ff @(posedge clk) begin
    per_cyl <= product[PER_CYL_W-1:0];
  end

  assign cfg.cylinder_count    = cylinder_count;
  assign cfg.head_count        = head_count;
  assign cfg.sectors_per_track = sectors_per_track;
  assign cfg.drive_number      = drive_number;
  assign cfg.per_cyl           = per_cyl;

endmodule

`default_nettype wire

// ===== rtl/core/lct_div_step.sv =====
// ---------------------------------------------------------------------------
// lct_div_step
// One registered restoring-division step: shift in a dividend bit,
// compare against the divisor, subtract on success.
// ---------------------------------------------------------------------------
`default_nettype none

module lct_div_step #(
  parameter int REM_W = 14
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             valid_in,
  input  wire logic [REM_W-1:0] rem_in,
  input  wire logic             bit_in,
  input  wire logic [REM_W-1:0] divisor,
  output logic                  valid_out,
  output logic [REM_W-1:0]      rem_out,
  output logic                  qbit
);
  logic [REM_W:0] trial;
  logic [REM_W:0] diff;
  logic           fits;

  assign trial = {rem_in, bit_in};
  assign diff  = trial - {1'b0, divisor};
  assign fits  = (trial >= {1'b0, divisor});

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_out <= 1'b0;
    end else begin
      valid_out <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    qbit    <= fits;
    rem_out <= fits ? diff[REM_W-1:0] : trial[REM_W-1:0];
  end

endmodule

`default_nettype wire

// ===== rtl/core/lct_pack.sv =====
// ---------------------------------------------------------------------------
// lct_pack
// Range checks, status and CX/DX packing; registered result stage.
// ---------------------------------------------------------------------------
`default_nettype none

module lct_pack #(
  parameter int ADDRESS_BITS = lct_pkg::ADDRESS_BITS_DEFAULT
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    valid_in,
  input  wire logic [ADDRESS_BITS-1:0] cyl_quo,
  input  wire logic [7:0]              head_quo,
  input  wire logic [lct_pkg::SPT_W-1:0] sec_rem,
  input  lct_pkg::cfg_t                cfg,
  output logic                         done,
  output logic [9:0]                   cylinder,
  output logic [7:0]                   head,
  output logic [5:0]                   sector,
  output logic [15:0]                  cx_word,
  output logic [15:0]                  dx_word,
  output logic [1:0]                   status
);
  import lct_pkg::*;

  logic       bad_geom;
  logic       beyond;
  logic [5:0] sec_one;

  assign bad_geom = (cfg.sectors_per_track == '0) || (cfg.head_count == '0);
  assign beyond   = (|cyl_quo[ADDRESS_BITS-1:10]) ||
                    ({1'b0, cyl_quo[9:0]} >= cfg.cylinder_count);
  assign sec_one  = sec_rem + 6'd1;

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (bad_geom || beyond) begin
      cylinder <= '0;
      head     <= '0;
      sector   <= '0;
      cx_word  <= '0;
      dx_word  <= '0;
      status   <= bad_geom ? STATUS_BAD_GEOM : STATUS_BEYOND;
    end else begin
      cylinder <= cyl_quo[9:0];
      head     <= head_quo;
      sector   <= sec_one;
      cx_word  <= {cyl_quo[7:0], cyl_quo[9:8], sec_one};
      dx_word  <= {head_quo, cfg.drive_number};
      status   <= STATUS_OK;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/lba_to_chs_translate.sv =====
// Done rises from the result register once a request has passed the input
// register and both division chains; the result is taken at the edge after that.
// Throughput: one request per cycle; busy is never raised.
// The cost is one restoring-division stage per quotient bit: ADDRESS_BITS stages
// for the cylinder, then 14 stages for head and sector.
// Reset clears all valid bits and loads the default geometry; done is low from
// the first clock edge in reset.
// ---------------------------------------------------------------------------
// lba_to_chs_translate
// Pipelined LBA to cylinder/head/sector translator with INT 13h CX/DX packing.
// ---------------------------------------------------------------------------
`default_nettype none

`include "lba_to_chs_translate_defines.svh"

module lba_to_chs_translate #(
  parameter int ADDRESS_BITS = lct_pkg::ADDRESS_BITS_DEFAULT
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            start,
  output logic                                 busy,
  input  wire logic [31:0]                     block_address,
  output logic                                 done,
  output logic [9:0]                           cylinder,
  output logic [7:0]                           head,
  output logic [5:0]                           sector,
  output logic [15:0]                          cx_word,
  output logic [15:0]                          dx_word,
  output logic [1:0]                           status,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [lct_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [lct_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import lct_pkg::*;

  localparam int LATENCY = ADDRESS_BITS + HEAD_DIV_STEPS + 2;

  cfg_t cfg;

  // cylinder division chain
  logic                    a_valid [0:ADDRESS_BITS];
  logic [PER_CYL_W-1:0]    a_rem   [0:ADDRESS_BITS];
  logic [ADDRESS_BITS-1:0] a_quo   [0:ADDRESS_BITS];
  logic [ADDRESS_BITS-1:0] a_lba   [0:ADDRESS_BITS];
  logic                    a_qbit  [1:ADDRESS_BITS];

  // head / sector division chain
  logic                    b_valid [0:HEAD_DIV_STEPS];
  logic [SPT_W-1:0]        b_rem   [0:HEAD_DIV_STEPS];
  logic [PER_CYL_W-1:0]    b_quo   [0:HEAD_DIV_STEPS];
  logic [PER_CYL_W-1:0]    b_div   [0:HEAD_DIV_STEPS];
  logic [ADDRESS_BITS-1:0] b_cyl   [0:HEAD_DIV_STEPS];
  logic                    b_qbit  [1:HEAD_DIV_STEPS];

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  lct_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid[0] <= 1'b0;
    end else begin
      a_valid[0] <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    a_lba[0] <= block_address[ADDRESS_BITS-1:0];
  end

  assign a_rem[0] = '0;
  assign a_quo[0] = '0;

  for (genvar k = 1; k <= ADDRESS_BITS; k++) begin : g_cyl
    lct_div_step #(.REM_W(PER_CYL_W)) u_step (
      .clk       (clk),
      .rst       (rst),
      .valid_in  (a_valid[k-1]),
      .rem_in    (a_rem[k-1]),
      .bit_in    (a_lba[k-1][ADDRESS_BITS-k]),
      .divisor   (cfg.per_cyl),
      .valid_out (a_valid[k]),
      .rem_out   (a_rem[k]),
      .qbit      (a_qbit[k])
    );

    always_ff @(posedge clk) begin
      a_lba[k] <= a_lba[k-1];
    end

    if (k == 1) begin : g_first
      assign a_quo[k] = {{(ADDRESS_BITS-1){1'b0}}, a_qbit[k]};
    end else begin : g_rest
      logic [ADDRESS_BITS-1:0] quo_prev;
      always_ff @(posedge clk) begin
        quo_prev <= a_quo[k-1];
      end
      assign a_quo[k] = {quo_prev[ADDRESS_BITS-2:0], a_qbit[k]};
    end
  end

  assign b_valid[0] = a_valid[ADDRESS_BITS];
  assign b_rem[0]   = '0;
  assign b_quo[0]   = '0;
  assign b_div[0]   = a_rem[ADDRESS_BITS];
  assign b_cyl[0]   = a_quo[ADDRESS_BITS];

  for (genvar k = 1; k <= HEAD_DIV_STEPS; k++) begin : g_head
    logic [PER_CYL_W-1:0] quo_prev;

    lct_div_step #(.REM_W(SPT_W)) u_step (
      .clk       (clk),
      .rst       (rst),
      .valid_in  (b_valid[k-1]),
      .rem_in    (b_rem[k-1]),
      .bit_in    (b_div[k-1][HEAD_DIV_STEPS-k]),
      .divisor   (cfg.sectors_per_track),
      .valid_out (b_valid[k]),
      .rem_out   (b_rem[k]),
      .qbit      (b_qbit[k])
    );

    always_ff @(posedge clk) begin
      b_div[k] <= b_div[k-1];
      b_cyl[k] <= b_cyl[k-1];
      quo_prev <= b_quo[k-1];
    end

    assign b_quo[k] = {quo_prev[PER_CYL_W-2:0], b_qbit[k]};
  end

  lct_pack #(.ADDRESS_BITS(ADDRESS_BITS)) u_pack (
    .clk      (clk),
    .rst      (rst),
    .valid_in (b_valid[HEAD_DIV_STEPS]),
    .cyl_quo  (b_cyl[HEAD_DIV_STEPS]),
    .head_quo (b_quo[HEAD_DIV_STEPS][7:0]),
    .sec_rem  (b_rem[HEAD_DIV_STEPS]),
    .cfg      (cfg),
    .done     (done),
    .cylinder (cylinder),
    .head     (head),
    .sector   (sector),
    .cx_word  (cx_word),
    .dx_word  (dx_word),
    .status   (status)
  );

  `LCT_ASSERT_NOW(a_latency, start && !busy, ##(LATENCY) done, "result missing after latency")
  `LCT_ASSERT_NOW(a_err_zero, done && (status != STATUS_OK), (cylinder == '0) && (head == '0) && (sector == '0) && (cx_word == '0) && (dx_word == '0), "error result carries data")
  `LCT_ASSERT_NOW(a_sector_nz, done && (status == STATUS_OK), sector != '0, "ok result with sector zero")
  `LCT_ASSERT_NOW(a_cyl_range, done && (status == STATUS_OK), {1'b0, cylinder} < cfg.cylinder_count, "ok result beyond cylinder count")
  `LCT_ASSERT_NEXT(a_drive, done && (status == STATUS_OK) && !cfg_valid, $past(dx_word[7:0]) == cfg.drive_number, "drive number not packed")

endmodule

`default_nettype wire

// ===== dv/tb.sv =====
// ---------------------------------------------------------------------------
// LBA to CHS translator testbench
// Drives block addresses through the translator under a series of disk
// geometries, predicts cylinder/head/sector, the packed CX/DX words and the
// status for each accepted request, and checks every result in order.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

import lct_pkg::*;

typedef struct packed {
  logic [9:0]  cylinder;
  logic [7:0]  head;
  logic [5:0]  sector;
  logic [15:0] cx_word;
  logic [15:0] dx_word;
  status_t     status;
} chs_fields_t;

class chs_scoreboard;
  localparam int MAX_CHS_CYL = 1023;

  logic [10:0]  cyl_count;
  logic [8:0]   head_count;
  logic [5:0]   spt;
  logic [7:0]   drive;
  chs_fields_t  pending_chs[$];
  int           errors;

  function new();
    cyl_count  = CYL_COUNT_RESET;
    head_count = HEAD_COUNT_RESET;
    spt        = SPT_RESET;
    drive      = DRIVE_RESET;
    errors     = 0;
  endfunction

  function void set_reg(cfg_index_t idx, logic [10:0] data);
    case (idx)
      CFG_CYL_COUNT:  cyl_count = data;
      CFG_HEAD_COUNT: head_count = data[8:0];
      CFG_SPT:        spt = data[5:0];
      CFG_DRIVE:      drive = data[7:0];
      default: ;
    endcase
  endfunction

  function int pending();
    return pending_chs.size();
  endfunction

  function chs_fields_t translate_lba(logic [31:0] lba);
    logic [31:0] heads;
    logic [31:0] per_cyl;
    logic [31:0] cyl;
    logic [31:0] hd;
    logic [31:0] sec;
    chs_fields_t r;
    r = '0;
    r.status = STATUS_OK;
    heads = (head_count > MAX_HEADS) ? 32'(MAX_HEADS) : 32'(head_count);
    if (spt == 0 || heads == 0) begin
      r.status = STATUS_BAD_GEOM;
      return r;
    end
    per_cyl = heads * 32'(spt);
    cyl = lba / per_cyl;
    hd  = (lba % per_cyl) / 32'(spt);
    sec = (lba % 32'(spt)) + 1;
    if (cyl >= 32'(cyl_count) || cyl > MAX_CHS_CYL) begin
      r.status = STATUS_BEYOND;
      return r;
    end
    r.cylinder = cyl[9:0];
    r.head     = hd[7:0];
    r.sector   = sec[5:0];
    r.cx_word  = {cyl[7:0], cyl[9:8], sec[5:0]};
    r.dx_word  = {hd[7:0], drive};
    return r;
  endfunction

  function void note_request(logic [31:0] lba);
    pending_chs.push_back(translate_lba(lba));
  endfunction

  task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    if (errors < 40)
      $display("mismatch %s: got %0h expected %0h", what, got, want);
    errors++;
  endtask

  task check_result(chs_fields_t got);
    chs_fields_t want;
    if (pending_chs.size() == 0) begin
      report_mismatch("result with no request", 32'(got.status), 32'hx);
      return;
    end
    want = pending_chs.pop_front();
    if (got.cylinder !== want.cylinder)
      report_mismatch("cylinder", 32'(got.cylinder), 32'(want.cylinder));
    if (got.head !== want.head)
      report_mismatch("head", 32'(got.head), 32'(want.head));
    if (got.sector !== want.sector)
      report_mismatch("sector", 32'(got.sector), 32'(want.sector));
    if (got.cx_word !== want.cx_word)
      report_mismatch("cx_word", 32'(got.cx_word), 32'(want.cx_word));
    if (got.dx_word !== want.dx_word)
      report_mismatch("dx_word", 32'(got.dx_word), 32'(want.dx_word));
    if (got.status !== want.status)
      report_mismatch("status", 32'(got.status), 32'(want.status));
  endtask
endclass

module tb;
  localparam int LIMIT_CYCLES = 400000;
  localparam int DRAIN_CYCLES = 60;
  localparam int PHASES = 14;
  localparam int PHASE_ITEMS = 95;

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  logic [31:0] block_address;
  logic        done;
  logic [9:0]  cylinder;
  logic [7:0]  head;
  logic [5:0]  sector;
  logic [15:0] cx_word;
  logic [15:0] dx_word;
  logic [1:0]  status;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  logic req_taken;
  logic cfg_taken;
  logic steady;
  int   cycles;
  chs_scoreboard sb;

  lba_to_chs_translate DUT (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .block_address(block_address),
    .done(done),
    .cylinder(cylinder),
    .head(head),
    .sector(sector),
    .cx_word(cx_word),
    .dx_word(dx_word),
    .status(status),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    req_taken <= !rst && start && !busy;
    cfg_taken <= !rst && cfg_valid && cfg_ready;
    cycles <= cycles + 1;
    if (!rst) begin
      if (cfg_valid && cfg_ready)
        sb.set_reg(cfg_index_t'(cfg_index), cfg_data);
      if (start && !busy)
        sb.note_request(block_address);
      if (done)
        sb.check_result({cylinder, head, sector, cx_word, dx_word, status_t'(status)});
    end
    if (cycles > LIMIT_CYCLES) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic logic idle_now();
    return !steady && ($urandom_range(0, 99) < 31);
  endfunction

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send_request(logic [31:0] addr);
    while (idle_now()) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start <= 1'b1;
    block_address <= addr;
    do @(negedge clk); while (!req_taken);
  endtask

  task automatic write_reg(cfg_index_t idx, logic [CFG_DATA_W-1:0] data);
    while (idle_now()) begin
      cfg_valid <= 1'b0;
      @(negedge clk);
    end
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(negedge clk); while (!cfg_taken);
  endtask

  task automatic program_geometry(logic [10:0] cyl, logic [8:0] hd, logic [5:0] spt,
                                  logic [7:0] drv);
    logic [10:0] data;
    write_reg(CFG_CYL_COUNT, cyl);
    data = 11'($urandom);
    data[8:0] = hd;
    write_reg(CFG_HEAD_COUNT, data);
    data = 11'($urandom);
    data[5:0] = spt;
    write_reg(CFG_SPT, data);
    data = 11'($urandom);
    data[7:0] = drv;
    write_reg(CFG_DRIVE, data);
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_drain();
    while (sb.pending() != 0) @(negedge clk);
  endtask

  // addresses mostly inside the geometry, some on its edge, some anywhere
  function automatic logic [31:0] pick_address();
    logic [31:0] heads;
    logic [31:0] cyl_lim;
    logic [31:0] cap;
    int r;
    heads = (sb.head_count > MAX_HEADS) ? 32'(MAX_HEADS) : 32'(sb.head_count);
    cyl_lim = (sb.cyl_count > 11'd1024) ? 32'd1024 : 32'(sb.cyl_count);
    cap = cyl_lim * heads * 32'(sb.spt);
    r = $urandom_range(0, 99);
    if (cap == 0 || r >= 80)
      return $urandom;
    if (r < 60)
      return $urandom_range(0, cap - 1);
    if (cap < 3)
      return $urandom_range(0, cap + 2);
    return cap - 2 + $urandom_range(0, 4);
  endfunction

  task automatic random_geometry();
    logic [10:0] cyl;
    logic [8:0]  hd;
    logic [5:0]  spt;
    logic [7:0]  drv;
    case ($urandom_range(0, 9))
      0: cyl = 11'($urandom);
      1: cyl = 11'd1024;
      default: cyl = 11'($urandom_range(1, 1024));
    endcase
    case ($urandom_range(0, 9))
      0: hd = 9'($urandom_range(257, 511));
      1: hd = 9'd256;
      default: hd = 9'($urandom_range(1, 256));
    endcase
    spt = ($urandom_range(0, 11) == 0) ? 6'd0 : 6'($urandom_range(1, 63));
    drv = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(128, 131));
    program_geometry(cyl, hd, spt, drv);
  endtask

  logic [31:0] directed_lba[13] = '{
    32'd0, 32'd1, 32'd62, 32'd63, 32'd64, 32'd16064, 32'd16065,
    32'd16450559, 32'd16450560, 32'hFFFF_FFFF, 32'hAAAA_AAAA, 32'h5555_5555,
    32'h8000_0000
  };

  initial begin
    sb = new();
    rst = 1'b1;
    start = 1'b0;
    block_address = '0;
    cfg_valid = 1'b0;
    cfg_index = CFG_CYL_COUNT;
    cfg_data = '0;
    steady = 1'b0;
    cycles = 0;
    req_taken = 1'b0;
    cfg_taken = 1'b0;
    repeat (12) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset geometry: sector, head and cylinder boundaries, last cylinder
    foreach (directed_lba[i])
      send_request(directed_lba[i]);

    for (int p = 0; p < PHASES; p++) begin
      start <= 1'b0;
      wait_drain();
      steady = (p == 8);
      case (p)
        0: program_geometry(11'd1, 9'd1, 6'd1, 8'd128);
        1: program_geometry(11'd1024, 9'd256, 6'd63, 8'd131);
        2: program_geometry(11'd2047, 9'd511, 6'd63, 8'd129);
        3: program_geometry(11'd0, 9'd16, 6'd63, 8'd130);
        4: program_geometry(11'd1024, 9'd0, 6'd63, 8'd255);
        5: program_geometry(11'd500, 9'd16, 6'd0, 8'd0);
        default: random_geometry();
      endcase
      send_request(32'd0);
      send_request(32'hFFFF_FFFF);
      for (int i = 2; i < PHASE_ITEMS; i++)
        send_request(pick_address());
    end

    start <= 1'b0;
    wait_drain();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (sb.errors == 0 && sb.pending() == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end
endmodule

// ===== lba_to_chs_translate.f =====
+incdir+rtl/core
rtl/core/lct_pkg.sv
rtl/core/lct_cfg_regs.sv
rtl/core/lct_div_step.sv
rtl/core/lct_pack.sv
rtl/core/lba_to_chs_translate.sv
dv/tb.sv
